// File: design/rsz_pkg.sv
package rsz_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int PIX_W     = 16;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 8;
  localparam int FRAC_W    = 8;
  localparam int POS_FRAC  = 16;
  localparam int CH_W      = 6;
  localparam int HSUM_W    = CH_W + FRAC_W;
  localparam int VSUM_W    = HSUM_W + FRAC_W;
  localparam int NUM_CH    = 3;

  localparam logic [FRAC_W:0] FRAC_ONE = 9'd256;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_REQ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd3;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef struct packed {
    logic valid;
    logic func;
    logic err;
  } rsz_ctl_t;

  typedef struct packed {
    rsz_ctl_t          ctl;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    logic              cx;
    logic              cy;
    logic              px;
    logic              py;
  } rsz_side_t;

  function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] p, input int k);
    logic [CH_W-1:0] c;
    unique case (k)
      CH_RED:   c = {1'b0, p[15:11]};
      CH_GREEN: c = p[10:5];
      default:  c = {1'b0, p[4:0]};
    endcase
    return c;
  endfunction

endpackage

// File: design/rsz_div.sv
module rsz_div #(
  parameter int N_W = 24,
  parameter int D_W = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             run_r;
  logic [CNT_W-1:0] cnt_r;
  logic [D_W-1:0]   rem_r;
  logic [N_W-1:0]   dvd_r;
  logic [D_W-1:0]   dvs_r;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             fits;

  assign trial = {rem_r, dvd_r[N_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (go) begin
      run_r <= 1'b1;
      cnt_r <= CNT_W'(N_W);
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
      dvd_r <= {dvd_r[N_W-2:0], fits};
    end
  end

  assign busy     = run_r;
  assign quotient = dvd_r;

endmodule

// File: design/rsz_store.sv
module rsz_store #(
  parameter int BA_W = 14
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [1:0]                       wr_bank,
  input  logic [BA_W-1:0]                  wr_addr,
  input  logic [rsz_pkg::PIX_W-1:0]        wr_data,
  input  logic [3:0][BA_W-1:0]             rd_addr,
  output logic [3:0][rsz_pkg::PIX_W-1:0]   rd_data
);
  import rsz_pkg::*;

  localparam int DEPTH = 2 ** BA_W;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == 2'(b)) mem[wr_addr] <= wr_data;
      rd_data[b] <= mem[rd_addr[b]];
    end
  end

endmodule

// File: design/rsz_blend.sv
module rsz_blend (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rsz_pkg::rsz_side_t               side,
  input  logic [3:0][rsz_pkg::PIX_W-1:0]   bank_data,
  output logic                             out_valid,
  output logic [rsz_pkg::PIX_W-1:0]        out_pixel_out,
  output logic                             out_coord_error
);
  import rsz_pkg::*;

  logic [PIX_W-1:0] p00, p10, p01, p11;
  logic [FRAC_W:0]  ifx, ify4;
  logic [1:0][NUM_CH-1:0][HSUM_W-1:0] h_nxt;
  logic [1:0][NUM_CH-1:0][HSUM_W-1:0] h4_r;
  logic [FRAC_W-1:0] fy4_r;
  rsz_ctl_t          ctl4_r;
  logic [NUM_CH-1:0][VSUM_W-1:0] v;
  logic              out_valid_r, out_err_r;
  logic [PIX_W-1:0]  out_pix_r;

  always_comb begin
    p00 = bank_data[{side.py, side.px}];
    p10 = side.cx ? p00 : bank_data[{side.py, ~side.px}];
    p01 = side.cy ? p00 : bank_data[{~side.py, side.px}];
    p11 = side.cy ? p10 :
          (side.cx ? bank_data[{~side.py, side.px}] : bank_data[{~side.py, ~side.px}]);
    ifx = FRAC_ONE - {1'b0, side.fx};
    for (int k = 0; k < NUM_CH; k++) begin
      h_nxt[0][k] = HSUM_W'(chan(p00, k)) * HSUM_W'(ifx) +
                    HSUM_W'(chan(p10, k)) * HSUM_W'(side.fx);
      h_nxt[1][k] = HSUM_W'(chan(p01, k)) * HSUM_W'(ifx) +
                    HSUM_W'(chan(p11, k)) * HSUM_W'(side.fx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ctl4_r <= '0;
    else        ctl4_r <= side.ctl;
  end

  always_ff @(posedge clk) begin
    h4_r  <= h_nxt;
    fy4_r <= side.fy;
  end

  always_comb begin
    ify4 = FRAC_ONE - {1'b0, fy4_r};
    for (int k = 0; k < NUM_CH; k++) begin
      v[k] = VSUM_W'(h4_r[0][k]) * VSUM_W'(ify4) + VSUM_W'(h4_r[1][k]) * VSUM_W'(fy4_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= ctl4_r.valid && ctl4_r.func == FUNC_REQ;
  end

  always_ff @(posedge clk) begin
    out_err_r <= ctl4_r.err;
    out_pix_r <= ctl4_r.err ? '0 :
                 {v[CH_RED][20:16], v[CH_GREEN][21:16], v[CH_BLUE][20:16]};
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = out_pix_r;
  assign out_coord_error = out_err_r;

endmodule

// File: design/rgb565_bilinear_resampler.sv
// An accepted request passes the stage 1, stage 2, stage 3, blend and output
// registers, and its result transaction is strobed by out_valid; one item
// per cycle while busy is low. Step computation (bit-serial divider) holds busy
// high after reset and after every configuration write.
// Synchronous active-low reset clears control and sizes; frame store is not cleared.
// The receiver cannot stall; results are never held off.
module rgb565_bilinear_resampler #(
  parameter int MAX_WIDTH  = rsz_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rsz_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_func,
  input  logic [rsz_pkg::COORD_W-1:0]     in_src_col,
  input  logic [rsz_pkg::COORD_W-1:0]     in_src_row,
  input  logic [rsz_pkg::PIX_W-1:0]       in_pixel_in,
  input  logic [rsz_pkg::COORD_W-1:0]     in_dest_col,
  input  logic [rsz_pkg::COORD_W-1:0]     in_dest_row,
  input  logic                            cfg_we,
  input  logic [rsz_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsz_pkg::CFG_W-1:0]       cfg_data,
  output logic                            out_valid,
  output logic [rsz_pkg::PIX_W-1:0]       out_pixel_out,
  output logic                            out_coord_error
);
  import rsz_pkg::*;

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_HEIGHT);
  localparam int WD_W    = $clog2(MAX_WIDTH + 1);
  localparam int HT_W    = $clog2(MAX_HEIGHT + 1);
  localparam int CSTEP_W = CW + POS_FRAC;
  localparam int RSTEP_W = RW + POS_FRAC;
  localparam int BA_W    = (CW + RW - 2 > 0) ? CW + RW - 2 : 1;
  localparam int RST_W   = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int RST_H   = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  function automatic logic [WD_W-1:0] sat_w(input logic [CFG_W-1:0] v);
    if (v == '0) return WD_W'(1);
    if (32'(v) > MAX_WIDTH) return WD_W'(MAX_WIDTH);
    return WD_W'(v);
  endfunction

  function automatic logic [HT_W-1:0] sat_h(input logic [CFG_W-1:0] v);
    if (v == '0) return HT_W'(1);
    if (32'(v) > MAX_HEIGHT) return HT_W'(MAX_HEIGHT);
    return HT_W'(v);
  endfunction

  function automatic logic [BA_W-1:0] bank_addr(input logic [CW:0] c, input logic [RW:0] r);
    logic [CW+RW+1:0] t;
    t = ((CW+RW+2)'(r >> 1) << (CW - 1)) | (CW+RW+2)'(c >> 1);
    return t[BA_W-1:0];
  endfunction

  // configuration
  logic [WD_W-1:0] in_w_r, out_w_r;
  logic [HT_W-1:0] in_h_r, out_h_r;
  logic            go_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_w_r  <= WD_W'(RST_W);
      in_h_r  <= HT_W'(RST_H);
      out_w_r <= WD_W'(RST_W);
      out_h_r <= HT_W'(RST_H);
      go_r    <= 1'b1;
    end else begin
      go_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IN_WIDTH:   in_w_r  <= sat_w(cfg_data);
          REG_IN_HEIGHT:  in_h_r  <= sat_h(cfg_data);
          REG_OUT_WIDTH:  out_w_r <= sat_w(cfg_data);
          REG_OUT_HEIGHT: out_h_r <= sat_h(cfg_data);
          default: ;
        endcase
      end
    end
  end

  logic               col_busy, row_busy;
  logic [CSTEP_W-1:0] col_q, col_step, col_dvd;
  logic [RSTEP_W-1:0] row_q, row_step, row_dvd;

  assign col_dvd = {CW'(in_w_r - WD_W'(1)), {POS_FRAC{1'b0}}};
  assign row_dvd = {RW'(in_h_r - HT_W'(1)), {POS_FRAC{1'b0}}};

  rsz_div #(.N_W(CSTEP_W), .D_W(WD_W)) u_div_col (
    .clk, .rst_n, .go(go_r), .dividend(col_dvd), .divisor(out_w_r - WD_W'(1)),
    .busy(col_busy), .quotient(col_q)
  );

  rsz_div #(.N_W(RSTEP_W), .D_W(HT_W)) u_div_row (
    .clk, .rst_n, .go(go_r), .dividend(row_dvd), .divisor(out_h_r - HT_W'(1)),
    .busy(row_busy), .quotient(row_q)
  );

  assign busy     = go_r | col_busy | row_busy;
  assign col_step = (out_w_r <= WD_W'(1)) ? '0 : col_q;
  assign row_step = (out_h_r <= HT_W'(1)) ? '0 : row_q;

  // stage 1: positions
  logic                       accept;
  logic [CSTEP_W+COORD_W-1:0] xprod;
  logic [RSTEP_W+COORD_W-1:0] yprod;
  rsz_ctl_t                   ctl1_nxt, ctl1_r;
  logic [CSTEP_W-1:0]         xfp1_r;
  logic [RSTEP_W-1:0]         yfp1_r;
  logic [COORD_W-1:0]         scol1_r, srow1_r;
  logic [PIX_W-1:0]           pix1_r;

  assign accept = start & ~busy;
  assign xprod  = in_dest_col * col_step;
  assign yprod  = in_dest_row * row_step;

  always_comb begin
    ctl1_nxt.valid = accept;
    ctl1_nxt.func  = in_func;
    ctl1_nxt.err   = (32'(in_dest_col) >= 32'(out_w_r)) ||
                     (32'(in_dest_row) >= 32'(out_h_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ctl1_r <= '0;
    else        ctl1_r <= ctl1_nxt;
  end

  always_ff @(posedge clk) begin
    xfp1_r  <= xprod[CSTEP_W-1:0];
    yfp1_r  <= yprod[RSTEP_W-1:0];
    scol1_r <= in_src_col;
    srow1_r <= in_src_row;
    pix1_r  <= in_pixel_in;
  end

  // stage 2: neighbor indexes, store access
  logic [CW-1:0]     ix_raw, ix_lim, ix_nxt;
  logic [RW-1:0]     iy_raw, iy_lim, iy_nxt;
  rsz_ctl_t          ctl2_r;
  logic [CW-1:0]     ix2_r, scol2_r;
  logic [RW-1:0]     iy2_r, srow2_r;
  logic [FRAC_W-1:0] fx2_r, fy2_r;
  logic              cx2_r, cy2_r, ld_ok2_r;
  logic [PIX_W-1:0]  pix2_r;

  assign ix_raw = xfp1_r[CSTEP_W-1:POS_FRAC];
  assign iy_raw = yfp1_r[RSTEP_W-1:POS_FRAC];
  assign ix_lim = CW'(in_w_r - WD_W'(1));
  assign iy_lim = RW'(in_h_r - HT_W'(1));
  assign ix_nxt = (ix_raw > ix_lim) ? ix_lim : ix_raw;
  assign iy_nxt = (iy_raw > iy_lim) ? iy_lim : iy_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) ctl2_r <= '0;
    else        ctl2_r <= ctl1_r;
  end

  always_ff @(posedge clk) begin
    ix2_r    <= ix_nxt;
    iy2_r    <= iy_nxt;
    cx2_r    <= ix_nxt == ix_lim;
    cy2_r    <= iy_nxt == iy_lim;
    fx2_r    <= xfp1_r[POS_FRAC-1:POS_FRAC-FRAC_W];
    fy2_r    <= yfp1_r[POS_FRAC-1:POS_FRAC-FRAC_W];
    scol2_r  <= CW'(scol1_r);
    srow2_r  <= RW'(srow1_r);
    ld_ok2_r <= (32'(scol1_r) < MAX_WIDTH) && (32'(srow1_r) < MAX_HEIGHT);
    pix2_r   <= pix1_r;
  end

  logic                   wr_en;
  logic [3:0][BA_W-1:0]   rd_addr;
  logic [3:0][PIX_W-1:0]  rd_data;

  assign wr_en = ctl2_r.valid && ctl2_r.func == FUNC_LOAD && ld_ok2_r;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      rd_addr[b] = bank_addr({1'b0, ix2_r} + (CW+1)'(ix2_r[0] ^ b[0]),
                             {1'b0, iy2_r} + (RW+1)'(iy2_r[0] ^ b[1]));
    end
  end

  rsz_store #(.BA_W(BA_W)) u_store (
    .clk,
    .wr_en,
    .wr_bank ({srow2_r[0], scol2_r[0]}),
    .wr_addr (bank_addr({1'b0, scol2_r}, {1'b0, srow2_r})),
    .wr_data (pix2_r),
    .rd_addr,
    .rd_data
  );

  // stage 3: side data aligned with store output
  rsz_side_t side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) side3_r <= '0;
    else begin
      side3_r.ctl <= ctl2_r;
      side3_r.fx  <= fx2_r;
      side3_r.fy  <= fy2_r;
      side3_r.cx  <= cx2_r;
      side3_r.cy  <= cy2_r;
      side3_r.px  <= ix2_r[0];
      side3_r.py  <= iy2_r[0];
    end
  end

  rsz_blend u_blend (
    .clk, .rst_n,
    .side      (side3_r),
    .bank_data (rd_data),
    .out_valid,
    .out_pixel_out,
    .out_coord_error
  );

  a_out_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_func == FUNC_REQ, 5))
    else $error("result without a matching request");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("busy not raised after configuration write");

  a_row_err: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_REQ && 32'(in_dest_row) >= 32'(out_h_r))
      |-> ##5 (out_valid && out_coord_error))
    else $error("row outside output size not flagged");

endmodule

// File: verif/rgb565_bilinear_resampler_tb.sv
module rgb565_bilinear_resampler_tb;
  import rsz_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE = 256;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_func;
  logic [COORD_W-1:0]   in_src_col;
  logic [COORD_W-1:0]   in_src_row;
  logic [PIX_W-1:0]     in_pixel_in;
  logic [COORD_W-1:0]   in_dest_col;
  logic [COORD_W-1:0]   in_dest_row;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 out_valid;
  logic [PIX_W-1:0]     out_pixel_out;
  logic                 out_coord_error;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             err;
  } resized_t;

  resized_t   resized_q[$];
  logic [PIX_W-1:0] src_frame[SIDE*SIDE];
  bit         loaded[SIDE*SIDE];
  int unsigned sz_in_w, sz_in_h, sz_out_w, sz_out_h;
  int unsigned step_x, step_y;
  int         mismatches;
  longint     cycles;
  bit         timed_out;

  rgb565_bilinear_resampler u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clamp_size(int unsigned v);
    if (v == 0) return 1;
    if (v > SIDE) return SIDE;
    return v;
  endfunction

  function automatic int unsigned step_for(int unsigned isz, int unsigned osz);
    if (osz <= 1) return 0;
    return (isz - 1) * 65536 / (osz - 1);
  endfunction

  function automatic int unsigned mix(int unsigned c00, int unsigned c10, int unsigned c01,
                                      int unsigned c11, int unsigned fx, int unsigned fy);
    int unsigned ifx, ify;
    ifx = 256 - fx;
    ify = 256 - fy;
    return ((c00 * ifx + c10 * fx) * ify + (c01 * ifx + c11 * fx) * fy) >> 16;
  endfunction

  function automatic resized_t resize_pixel(int unsigned dc, int unsigned dr);
    resized_t r;
    int unsigned xp, yp, ix, iy, ix1, iy1, fx, fy;
    logic [PIX_W-1:0] p00, p10, p01, p11;
    int unsigned rd, gr, bl;
    r = '0;
    if (dc >= sz_out_w || dr >= sz_out_h) begin
      r.err = 1'b1;
      return r;
    end
    xp = dc * step_x;
    yp = dr * step_y;
    ix = xp >> 16;
    iy = yp >> 16;
    fx = (xp >> 8) & 8'hFF;
    fy = (yp >> 8) & 8'hFF;
    if (ix > sz_in_w - 1) ix = sz_in_w - 1;
    if (iy > sz_in_h - 1) iy = sz_in_h - 1;
    ix1 = (ix < sz_in_w - 1) ? ix + 1 : ix;
    iy1 = (iy < sz_in_h - 1) ? iy + 1 : iy;
    p00 = src_frame[iy * SIDE + ix];
    p10 = src_frame[iy * SIDE + ix1];
    p01 = src_frame[iy1 * SIDE + ix];
    p11 = src_frame[iy1 * SIDE + ix1];
    rd = mix(p00[15:11], p10[15:11], p01[15:11], p11[15:11], fx, fy);
    gr = mix(p00[10:5], p10[10:5], p01[10:5], p11[10:5], fx, fy);
    bl = mix(p00[4:0], p10[4:0], p01[4:0], p11[4:0], fx, fy);
    r.pixel = {rd[4:0], gr[5:0], bl[4:0]};
    return r;
  endfunction

  function automatic bit footprint_loaded(int unsigned dc, int unsigned dr);
    int unsigned ix, iy, ix1, iy1;
    if (dc >= sz_out_w || dr >= sz_out_h) return 1;
    ix = (dc * step_x) >> 16;
    iy = (dr * step_y) >> 16;
    if (ix > sz_in_w - 1) ix = sz_in_w - 1;
    if (iy > sz_in_h - 1) iy = sz_in_h - 1;
    ix1 = (ix < sz_in_w - 1) ? ix + 1 : ix;
    iy1 = (iy < sz_in_h - 1) ? iy + 1 : iy;
    return loaded[iy*SIDE+ix] && loaded[iy*SIDE+ix1] && loaded[iy1*SIDE+ix] &&
           loaded[iy1*SIDE+ix1];
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (resized_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    int unsigned v;
    wait_drained();
    v = val & 9'h1FF;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IN_WIDTH:   sz_in_w = clamp_size(v);
      REG_IN_HEIGHT:  sz_in_h = clamp_size(v);
      REG_OUT_WIDTH:  sz_out_w = clamp_size(v);
      default:        sz_out_h = clamp_size(v);
    endcase
    step_x = step_for(sz_in_w, sz_out_w);
    step_y = step_for(sz_in_h, sz_out_h);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_sizes(int unsigned iw, int unsigned ih, int unsigned ow, int unsigned oh);
    write_reg(REG_IN_WIDTH, iw);
    write_reg(REG_IN_HEIGHT, ih);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_OUT_HEIGHT, oh);
  endtask

  task automatic send_item(logic func, logic [7:0] sc, logic [7:0] sr, logic [15:0] pix,
                           logic [7:0] dc, logic [7:0] dr, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_src_col <= sc;
    in_src_row <= sr;
    in_pixel_in <= pix;
    in_dest_col <= dc;
    in_dest_row <= dr;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (func == FUNC_LOAD) begin
      src_frame[sr*SIDE+sc] = pix;
      loaded[sr*SIDE+sc] = 1'b1;
    end else begin
      resized_q.push_back(resize_pixel(dc, dr));
    end
  endtask

  task automatic load_pixel(int unsigned c, int unsigned r, logic [15:0] pix, int unsigned gap);
    send_item(FUNC_LOAD, c[7:0], r[7:0], pix, 8'($urandom), 8'($urandom), gap);
  endtask

  task automatic request_pixel(int unsigned c, int unsigned r, int unsigned gap);
    send_item(FUNC_REQ, 8'($urandom), 8'($urandom), 16'($urandom), c[7:0], r[7:0], gap);
  endtask

  function automatic int unsigned rand_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic test_directed_extremes();
    set_sizes(2, 2, 3, 3);
    load_pixel(0, 0, 16'h0000, 0);
    load_pixel(1, 0, 16'hFFFF, 0);
    load_pixel(0, 1, 16'hF800, 0);
    load_pixel(1, 1, 16'h07FF, 0);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) request_pixel(c, r, 0);
    request_pixel(3, 0, 0);
    request_pixel(0, 255, 0);
    request_pixel(255, 255, 0);
    load_pixel(255, 255, 16'hA5A5, 0);
    load_pixel(255, 0, 16'h5A5A, 0);
    load_pixel(0, 255, 16'h1234, 0);
    write_reg(REG_IN_WIDTH, 0);
    write_reg(REG_OUT_WIDTH, 511);
    request_pixel(255, 0, 0);
    request_pixel(0, 0, 0);
  endtask

  task automatic test_full_frame_corners();
    set_sizes(256, 256, 1, 1);
    load_pixel(0, 0, 16'hBEEF, 0);
    request_pixel(0, 0, 0);
    request_pixel(1, 0, 0);
    set_sizes(300, 400, 256, 256);
    load_pixel(254, 254, 16'h1111, 0);
    load_pixel(254, 255, 16'h2222, 0);
    load_pixel(255, 254, 16'h3333, 0);
    request_pixel(255, 255, 0);
    request_pixel(254, 254, 0);
  endtask

  task automatic test_random_frames();
    int unsigned n, iw, ih, ow, oh, c, r;
    n = 0;
    while (n < 600) begin
      case ($urandom_range(0, 3))
        0: begin iw = $urandom_range(1, 4); ih = $urandom_range(1, 4); end
        1: begin iw = $urandom_range(2, 8); ih = $urandom_range(2, 8); end
        2: begin iw = $urandom_range(1, 12); ih = $urandom_range(1, 12); end
        default: begin iw = $urandom_range(0, 511); ih = $urandom_range(0, 511); end
      endcase
      ow = $urandom_range(0, 3) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 20);
      oh = $urandom_range(0, 3) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 20);
      set_sizes(iw, ih, ow, oh);
      for (r = 0; r < clamp_size(ih & 9'h1FF) && r < 12; r++)
        for (c = 0; c < clamp_size(iw & 9'h1FF) && c < 12; c++) begin
          load_pixel(c, r, 16'($urandom), rand_gap());
          n++;
        end
      repeat (30) begin
        if ($urandom_range(0, 7) == 0) begin
          c = $urandom_range(0, 255);
          r = $urandom_range(0, 255);
        end else begin
          c = $urandom_range(0, sz_out_w);
          r = $urandom_range(0, sz_out_h);
        end
        if (footprint_loaded(c & 32'hFF, r & 32'hFF)) begin
          request_pixel(c, r, rand_gap());
          n++;
        end
        if ($urandom_range(0, 9) == 0) begin
          load_pixel($urandom_range(0, 255), $urandom_range(0, 255), 16'($urandom),
                     rand_gap());
          n++;
        end
      end
      if (n > 300 && n < 340) wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (resized_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: pixel %h err %b",
                                       out_pixel_out, out_coord_error);
      end else begin
        resized_t e;
        e = resized_q.pop_front();
        if (e.pixel !== out_pixel_out || e.err !== out_coord_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected pixel %h err %b, got pixel %h err %b",
                     e.pixel, e.err, out_pixel_out, out_coord_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000 && !timed_out) begin
      timed_out = 1'b1;
      $display("rgb565_bilinear_resampler regression: fail");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    timed_out = 1'b0;
    foreach (src_frame[i]) src_frame[i] = '0;
    sz_in_w = SIDE;
    sz_in_h = SIDE;
    sz_out_w = SIDE;
    sz_out_h = SIDE;
    step_x = step_for(sz_in_w, sz_out_w);
    step_y = step_for(sz_in_h, sz_out_h);
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_LOAD;
    in_src_col = '0;
    in_src_row = '0;
    in_pixel_in = '0;
    in_dest_col = '0;
    in_dest_row = '0;
    cfg_we = 1'b0;
    cfg_index = REG_IN_WIDTH;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    test_directed_extremes();
    test_full_frame_corners();
    test_random_frames();
    wait_drained();
    if (mismatches == 0 && resized_q.size() == 0) begin
      $display("rgb565_bilinear_resampler regression: pass");
    end else begin
      $display("rgb565_bilinear_resampler regression: fail");
    end
    $finish;
  end

endmodule
